// ----- sv/inertia_tensor_accumulator_macros.svh -----
// ----------------------------------------------------------------------------
// inertia tensor accumulator assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef INERTIA_TENSOR_ACCUMULATOR_MACROS_SVH
`define INERTIA_TENSOR_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define ITACC_ASSERT_IMPLY(name, cond, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ITACC_ASSERT_NEXT(name, cond, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/itacc_pkg.sv -----
// ----------------------------------------------------------------------------
// itacc_pkg
// shared types and constants of the inertia tensor accumulator
// ----------------------------------------------------------------------------
package itacc_pkg;

    localparam int COORD_WIDTH = 20;
    localparam int MASS_WIDTH  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int NUM_SUMS    = 6;
    localparam int SUM_WIDTH   = 64;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_CENTER_Z = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [MASS_WIDTH-1:0]         mass;
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [COORD_WIDTH-1:0] pos_z;
        logic                          last_point;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_WIDTH-1:0] tensor_xx;
        logic signed [SUM_WIDTH-1:0] tensor_yy;
        logic signed [SUM_WIDTH-1:0] tensor_zz;
        logic signed [SUM_WIDTH-1:0] tensor_xy;
        logic signed [SUM_WIDTH-1:0] tensor_xz;
        logic signed [SUM_WIDTH-1:0] tensor_yz;
    } t_out_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic pop;
    } t_back_ctrl;

endpackage

// ----- sv/itacc_front.sv -----
// ----------------------------------------------------------------------------
// itacc_front
// accepts point items, forms center offsets, magnitudes and term signs
// ----------------------------------------------------------------------------
module itacc_front #(
    parameter int COORD_WIDTH = itacc_pkg::COORD_WIDTH,
    parameter int MASS_WIDTH  = itacc_pkg::MASS_WIDTH,
    localparam int AW = COORD_WIDTH + 1,
    localparam int QW = 4 + MASS_WIDTH + 3 * AW
) (
    input  logic                          i_valid,
    output logic                          o_stall,
    input  itacc_pkg::t_in_item           i_item,
    input  logic signed [COORD_WIDTH-1:0] i_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_center_y,
    input  logic signed [COORD_WIDTH-1:0] i_center_z,
    input  itacc_pkg::t_queue_status      i_q_status,
    output logic                          o_push,
    output logic [QW-1:0]                 o_entry
);

    logic signed [COORD_WIDTH-1:0] px, py, pz;
    logic signed [COORD_WIDTH:0]   dx, dy, dz;
    logic [AW-1:0]                 ax, ay, az;
    logic [2:0]                    neg;

    always_comb begin
        px = COORD_WIDTH'(i_item.pos_x);
        py = COORD_WIDTH'(i_item.pos_y);
        pz = COORD_WIDTH'(i_item.pos_z);
        dx = {px[COORD_WIDTH-1], px} - {i_center_x[COORD_WIDTH-1], i_center_x};
        dy = {py[COORD_WIDTH-1], py} - {i_center_y[COORD_WIDTH-1], i_center_y};
        dz = {pz[COORD_WIDTH-1], pz} - {i_center_z[COORD_WIDTH-1], i_center_z};
        ax = dx[COORD_WIDTH] ? AW'(-dx) : AW'(dx);
        ay = dy[COORD_WIDTH] ? AW'(-dy) : AW'(dy);
        az = dz[COORD_WIDTH] ? AW'(-dz) : AW'(dz);
        // off-diagonal term is negative when the offsets share a sign
        neg[0] = (dx[COORD_WIDTH] == dy[COORD_WIDTH]);
        neg[1] = (dx[COORD_WIDTH] == dz[COORD_WIDTH]);
        neg[2] = (dy[COORD_WIDTH] == dz[COORD_WIDTH]);
    end

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;
    assign o_entry = {i_item.last_point, neg, MASS_WIDTH'(i_item.mass), ax, ay, az};

endmodule

// ----- sv/itacc_queue.sv -----
// ----------------------------------------------------------------------------
// itacc_queue
// small first-in first-out queue between the front and the back
// ----------------------------------------------------------------------------
module itacc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = itacc_pkg::QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [WIDTH-1:0]         i_data,
    input  itacc_pkg::t_back_ctrl    i_ctrl,
    output itacc_pkg::t_queue_status o_status,
    output logic [WIDTH-1:0]         o_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_ctrl.pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_ctrl.pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_ctrl.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// ----- sv/itacc_back.sv -----
// ----------------------------------------------------------------------------
// itacc_back
// product pipeline, term clamping, saturating sums and result register
// ----------------------------------------------------------------------------
module itacc_back #(
    parameter int COORD_WIDTH = itacc_pkg::COORD_WIDTH,
    parameter int MASS_WIDTH  = itacc_pkg::MASS_WIDTH,
    localparam int AW  = COORD_WIDTH + 1,
    localparam int QW  = 4 + MASS_WIDTH + 3 * AW,
    localparam int PW  = 2 * AW,
    localparam int SW  = PW + 1,
    localparam int LOW = 32,
    localparam int HIW = (SW > LOW) ? SW - LOW : 1,
    localparam int OPW = LOW + HIW,
    localparam int LPW = MASS_WIDTH + LOW,
    localparam int HPW = MASS_WIDTH + HIW,
    localparam int EW  = (MASS_WIDTH + OPW > 65) ? MASS_WIDTH + OPW : 65,
    localparam int NS  = itacc_pkg::NUM_SUMS,
    localparam int DW  = itacc_pkg::SUM_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  itacc_pkg::t_queue_status i_q_status,
    input  logic [QW-1:0]            i_q_data,
    output itacc_pkg::t_back_ctrl    o_ctrl,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output itacc_pkg::t_out_item     o_out_item
);

    localparam logic [DW-1:0] SUM_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SUM_MIN = {1'b1, {(DW-1){1'b0}}};

    logic                  en;
    logic [AW-1:0]         q_ax, q_ay, q_az;
    logic [MASS_WIDTH-1:0] q_mass;
    logic [2:0]            q_neg;
    logic                  q_last;

    logic                  r1_v, r1_last;
    logic [MASS_WIDTH-1:0] r1_mass;
    logic [2:0]            r1_neg;
    logic [PW-1:0]         r1_prod [NS];

    logic                  r2_v, r2_last;
    logic [2:0]            r2_neg;
    logic [LPW-1:0]        r2_lo [NS];
    logic [HPW-1:0]        r2_hi [NS];

    logic                  r3_v, r3_last;
    logic signed [DW-1:0]  r3_term [NS];

    logic signed [DW-1:0]  r_sum [NS];
    logic signed [DW-1:0]  n_sum [NS];
    logic [SW-1:0]         op [NS];
    logic [OPW-1:0]        opx [NS];
    logic [EW-1:0]         full [NS];
    logic [NS-1:0]         term_neg;
    logic signed [DW-1:0]  term [NS];
    logic signed [DW-1:0]  add [NS];
    logic                  r_out_valid;
    itacc_pkg::t_out_item  r_out_item;

    assign en = !(r_out_valid && i_out_stall);
    assign o_ctrl.pop = en && !i_q_status.empty;

    assign q_az   = i_q_data[AW-1:0];
    assign q_ay   = i_q_data[2*AW-1:AW];
    assign q_ax   = i_q_data[3*AW-1:2*AW];
    assign q_mass = i_q_data[3*AW+MASS_WIDTH-1:3*AW];
    assign q_neg  = i_q_data[3*AW+MASS_WIDTH+2:3*AW+MASS_WIDTH];
    assign q_last = i_q_data[QW-1];

    // squares and cross products of the offset magnitudes
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_mass    <= q_mass;
            r1_neg     <= q_neg;
            r1_last    <= q_last;
            r1_prod[0] <= PW'(q_ax) * PW'(q_ax);
            r1_prod[1] <= PW'(q_ay) * PW'(q_ay);
            r1_prod[2] <= PW'(q_az) * PW'(q_az);
            r1_prod[3] <= PW'(q_ax) * PW'(q_ay);
            r1_prod[4] <= PW'(q_ax) * PW'(q_az);
            r1_prod[5] <= PW'(q_ay) * PW'(q_az);
        end
    end

    always_comb begin
        op[0] = SW'(r1_prod[1]) + SW'(r1_prod[2]);
        op[1] = SW'(r1_prod[0]) + SW'(r1_prod[2]);
        op[2] = SW'(r1_prod[0]) + SW'(r1_prod[1]);
        op[3] = SW'(r1_prod[3]);
        op[4] = SW'(r1_prod[4]);
        op[5] = SW'(r1_prod[5]);
        for (int i = 0; i < NS; i++) begin
            opx[i] = OPW'(op[i]);
        end
    end

    // mass times operand, split into low and high partial products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_neg  <= r1_neg;
            r2_last <= r1_last;
            for (int i = 0; i < NS; i++) begin
                r2_lo[i] <= LPW'(r1_mass) * LPW'(opx[i][LOW-1:0]);
                r2_hi[i] <= HPW'(r1_mass) * HPW'(opx[i][OPW-1:LOW]);
            end
        end
    end

    // combine partials and clamp each term to the signed range
    always_comb begin
        term_neg = {r2_neg, 3'b000};
        for (int i = 0; i < NS; i++) begin
            full[i] = EW'(r2_lo[i]) + (EW'(r2_hi[i]) << LOW);
            if (term_neg[i]) begin
                term[i] = (full[i] >= EW'(SUM_MIN)) ? signed'(SUM_MIN)
                                                    : -signed'(DW'(full[i]));
            end else begin
                term[i] = (full[i] > EW'(SUM_MAX)) ? signed'(SUM_MAX)
                                                   : signed'(DW'(full[i]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_last <= r2_last;
            for (int i = 0; i < NS; i++) begin
                r3_term[i] <= term[i];
            end
        end
    end

    // saturating accumulation
    always_comb begin
        for (int i = 0; i < NS; i++) begin
            add[i] = r_sum[i] + r3_term[i];
            if (r_sum[i][DW-1] == r3_term[i][DW-1] && add[i][DW-1] != r3_term[i][DW-1]) begin
                n_sum[i] = r3_term[i][DW-1] ? signed'(SUM_MIN) : signed'(SUM_MAX);
            end else begin
                n_sum[i] = add[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NS; i++) begin
                r_sum[i] <= '0;
            end
        end else if (en) begin
            r1_v <= !i_q_status.empty;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r_out_valid <= r3_v && r3_last;
            if (r3_v) begin
                for (int i = 0; i < NS; i++) begin
                    r_sum[i] <= r3_last ? '0 : n_sum[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r3_v && r3_last) begin
            r_out_item.tensor_xx <= n_sum[0];
            r_out_item.tensor_yy <= n_sum[1];
            r_out_item.tensor_zz <= n_sum[2];
            r_out_item.tensor_xy <= n_sum[3];
            r_out_item.tensor_xz <= n_sum[4];
            r_out_item.tensor_yz <= n_sum[5];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- sv/inertia_tensor_accumulator.sv -----
// ----------------------------------------------------------------------------
// inertia_tensor_accumulator
// streaming 3d moment of inertia tensor over point masses
// ----------------------------------------------------------------------------
// Takes one point item per cycle, sustained, as long as the result side is not
// held: the front forms the offsets from the configured center and writes them
// into a four-entry queue, and the back runs a four-stage product, clamp and
// accumulate pipeline that also takes one item per cycle. The six tensor sums
// of a structure appear once its last point has passed the product, partial,
// term and result registers; while a result is held by the receiver the back
// stops and the queue absorbs up to four more items before the input stalls.
module inertia_tensor_accumulator #(
    parameter int COORD_WIDTH = itacc_pkg::COORD_WIDTH,
    parameter int MASS_WIDTH  = itacc_pkg::MASS_WIDTH,
    parameter int QUEUE_DEPTH = itacc_pkg::QUEUE_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [itacc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]               i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  itacc_pkg::t_in_item                  i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output itacc_pkg::t_out_item                 o_out_item
);

    localparam int AW = COORD_WIDTH + 1;
    localparam int QW = 4 + MASS_WIDTH + 3 * AW;

    logic signed [COORD_WIDTH-1:0] r_center_x, r_center_y, r_center_z;
    itacc_pkg::t_queue_status      q_status;
    itacc_pkg::t_back_ctrl         back_ctrl;
    logic                          push;
    logic [QW-1:0]                 entry, q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
        end else if (i_cfg_we) begin
            unique case (itacc_pkg::t_cfg_idx'(i_cfg_idx))
                itacc_pkg::CFG_CENTER_X: r_center_x <= COORD_WIDTH'(i_cfg_data);
                itacc_pkg::CFG_CENTER_Y: r_center_y <= COORD_WIDTH'(i_cfg_data);
                itacc_pkg::CFG_CENTER_Z: r_center_z <= COORD_WIDTH'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    itacc_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .MASS_WIDTH  (MASS_WIDTH)
    ) u_front (
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_item     (i_in_item),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_center_z (r_center_z),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (entry)
    );

    itacc_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (entry),
        .i_ctrl   (back_ctrl),
        .o_status (q_status),
        .o_data   (q_data)
    );

    itacc_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .MASS_WIDTH  (MASS_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_q_data    (q_data),
        .o_ctrl      (back_ctrl),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

`include "inertia_tensor_accumulator_macros.svh"

    `ITACC_ASSERT_NEXT(a_push_fills_queue, i_in_valid && !o_in_stall, !q_status.empty, "accepted item missing from queue")
    `ITACC_ASSERT_IMPLY(a_no_pop_when_empty, q_status.empty, !back_ctrl.pop, "pop from empty queue")
    `ITACC_ASSERT_IMPLY(a_no_pop_when_held, o_out_valid && i_out_stall, !back_ctrl.pop, "pop while result held")

endmodule
